// ===== rtl/fcou_pkg.sv =====
// Shared types, constants and tables for the fly camera orientation update block.
// Used by fcou_cordic, fcou_norm and fly_camera_orientation_update; depends on nothing.
package fcou_pkg;

    // Angles in 1/128 degree
    localparam int DEG360 = 46080;
    localparam int DEG180 = 23040;
    localparam int DEG90  = 11520;
    localparam int DEG89  = 11392;
    // Q1.14 one
    localparam int ONE14  = 16384;

    // CORDIC start x (gain compensated, Q2.30)
    localparam logic signed [32:0] CORDIC_X0 = 33'sd652032874;
    // arctangent table depth and its index width
    localparam int ATAN_LEN = 24;
    localparam int STEP_W   = 5;

    // request kinds
    localparam logic [1:0] ACT_MOVE   = 2'd0;
    localparam logic [1:0] ACT_LOOK   = 2'd1;
    localparam logic [1:0] ACT_RELOAD = 2'd2;

    // move directions
    localparam logic [2:0] DIR_FWD   = 3'd0;
    localparam logic [2:0] DIR_BACK  = 3'd1;
    localparam logic [2:0] DIR_LEFT  = 3'd2;
    localparam logic [2:0] DIR_RIGHT = 3'd3;

    // configuration register indexes
    localparam logic [2:0] CFG_SPEED  = 3'd0;
    localparam logic [2:0] CFG_SENS   = 3'd1;
    localparam logic [2:0] CFG_WUP    = 3'd2;
    localparam logic [2:0] CFG_SX     = 3'd3;
    localparam logic [2:0] CFG_SY     = 3'd4;
    localparam logic [2:0] CFG_SZ     = 3'd5;
    localparam logic [2:0] CFG_SYAW   = 3'd6;
    localparam logic [2:0] CFG_SPITCH = 3'd7;

    // wide vector component (cross products) and packed Q1.14 component
    typedef logic signed [32:0] wcomp_t;
    typedef logic signed [15:0] vcomp_t;

    // normalizer status back to the sequencer
    typedef struct packed {
        logic done;
        logic ok;
    } norm_stat_t;

    // atan(2^-i) in degrees * 2^16
    function automatic logic [21:0] atan_val(input logic [STEP_W-1:0] idx);
        logic [21:0] v;
        begin
            case (idx)
                5'd0:    v = 22'd2949120;
                5'd1:    v = 22'd1740967;
                5'd2:    v = 22'd919879;
                5'd3:    v = 22'd466945;
                5'd4:    v = 22'd234379;
                5'd5:    v = 22'd117304;
                5'd6:    v = 22'd58666;
                5'd7:    v = 22'd29335;
                5'd8:    v = 22'd14668;
                5'd9:    v = 22'd7334;
                5'd10:   v = 22'd3667;
                5'd11:   v = 22'd1833;
                5'd12:   v = 22'd917;
                5'd13:   v = 22'd458;
                5'd14:   v = 22'd229;
                5'd15:   v = 22'd115;
                5'd16:   v = 22'd57;
                5'd17:   v = 22'd29;
                5'd18:   v = 22'd14;
                5'd19:   v = 22'd7;
                5'd20:   v = 22'd4;
                5'd21:   v = 22'd2;
                5'd22:   v = 22'd1;
                default: v = 22'd0;
            endcase
            return v;
        end
    endfunction

    // one component of a packed vector, x lowest
    function automatic vcomp_t vec_comp(input logic [47:0] v, input logic [1:0] j);
        vcomp_t c;
        begin
            case (j)
                2'd0:    c = v[15:0];
                2'd1:    c = v[31:16];
                default: c = v[47:32];
            endcase
            return c;
        end
    endfunction

endpackage

// ===== rtl/fcou_cordic.sv =====
// Iterative CORDIC rotation: sine and cosine of an angle in 1/128 degree, Q1.14 out.
// Depends on fcou_pkg (angle constants, arctangent table).
module fcou_cordic #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic signed [19:0]     angle,
    output logic                   done,
    output fcou_pkg::vcomp_t       sin_val,
    output fcou_pkg::vcomp_t       cos_val
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RED,
        S_FOLD,
        S_ITER,
        S_FIN
    } state_t;

    localparam logic [fcou_pkg::STEP_W-1:0] LAST_STEP =
        (fcou_pkg::STEP_W)'(CORDIC_STEPS - 1);

    state_t                         state_reg;
    logic signed [19:0]             a_reg;
    logic signed [32:0]             x_reg;
    logic signed [32:0]             y_reg;
    logic signed [25:0]             z_reg;
    logic [fcou_pkg::STEP_W-1:0]    step_reg;
    logic                           neg_reg;
    logic                           done_reg;
    fcou_pkg::vcomp_t               sin_reg;
    fcou_pkg::vcomp_t               cos_reg;

    logic signed [19:0]             fold_a;
    logic                           fold_neg;
    logic signed [32:0]             dx;
    logic signed [32:0]             dy;
    logic signed [25:0]             at;
    logic signed [32:0]             xf;
    logic signed [32:0]             yf;
    logic signed [32:0]             xr;
    logic signed [32:0]             yr;

    function automatic fcou_pkg::vcomp_t sat14(input logic signed [32:0] v);
        fcou_pkg::vcomp_t r;
        begin
            if (v > 33'sd16384)
                r = 16'sd16384;
            else if (v < -33'sd16384)
                r = -16'sd16384;
            else
                r = v[15:0];
            return r;
        end
    endfunction

    // fold into [-90, 90] degrees, a_reg already inside one turn
    always_comb
    begin
        fold_a   = a_reg;
        fold_neg = 1'b0;
        if (fold_a < 20'sd0)
            fold_a = fold_a + 20'sd46080;
        if (fold_a >= 20'sd23040)
            fold_a = fold_a - 20'sd46080;
        if (fold_a > 20'sd11520)
        begin
            fold_a   = fold_a - 20'sd23040;
            fold_neg = 1'b1;
        end
        else if (fold_a < -20'sd11520)
        begin
            fold_a   = fold_a + 20'sd23040;
            fold_neg = 1'b1;
        end
    end

    assign dx = y_reg >>> step_reg;
    assign dy = x_reg >>> step_reg;
    assign at = {4'd0, fcou_pkg::atan_val(step_reg)};
    assign xf = neg_reg ? -x_reg : x_reg;
    assign yf = neg_reg ? -y_reg : y_reg;
    assign xr = (xf + 33'sd32768) >>> 16;
    assign yr = (yf + 33'sd32768) >>> 16;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            a_reg     <= '0;
            x_reg     <= '0;
            y_reg     <= '0;
            z_reg     <= '0;
            step_reg  <= '0;
            neg_reg   <= 1'b0;
            done_reg  <= 1'b0;
            sin_reg   <= '0;
            cos_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        a_reg     <= angle;
                        state_reg <= S_RED;
                    end
                end
                S_RED:
                begin
                    // truncating modulo of one turn, one add or subtract a cycle
                    if (a_reg >= 20'sd46080)
                        a_reg <= a_reg - 20'sd46080;
                    else if (a_reg <= -20'sd46080)
                        a_reg <= a_reg + 20'sd46080;
                    else
                        state_reg <= S_FOLD;
                end
                S_FOLD:
                begin
                    x_reg     <= fcou_pkg::CORDIC_X0;
                    y_reg     <= '0;
                    z_reg     <= 26'(fold_a) <<< 9;
                    neg_reg   <= fold_neg;
                    step_reg  <= '0;
                    state_reg <= S_ITER;
                end
                S_ITER:
                begin
                    if (z_reg >= 26'sd0)
                    begin
                        x_reg <= x_reg - dx;
                        y_reg <= y_reg + dy;
                        z_reg <= z_reg - at;
                    end
                    else
                    begin
                        x_reg <= x_reg + dx;
                        y_reg <= y_reg - dy;
                        z_reg <= z_reg + at;
                    end
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == LAST_STEP)
                        state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    cos_reg   <= sat14(xr);
                    sin_reg   <= sat14(yr);
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign done    = done_reg;
    assign sin_val = sin_reg;
    assign cos_val = cos_reg;

endmodule

// ===== rtl/fcou_norm.sv =====
// Vector normalizer: prescale, sum of squares, bit-serial square root, restoring division.
// Depends on fcou_pkg (component types, status struct).
module fcou_norm (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  fcou_pkg::wcomp_t        comp_in [3],
    output logic [47:0]             res,
    output fcou_pkg::norm_stat_t    stat
);

    typedef enum logic [2:0] {
        N_IDLE,
        N_SHIFT,
        N_SQ,
        N_SQRT,
        N_DLOAD,
        N_DIV,
        N_FIN,
        N_FAIL
    } state_t;

    state_t                 state_reg;
    fcou_pkg::wcomp_t       c_reg [3];
    logic [1:0]             j_reg;
    logic [59:0]            prod_reg;
    logic [61:0]            acc_reg;
    logic [63:0]            v_reg;
    logic [63:0]            r_reg;
    logic [63:0]            bit_reg;
    logic [30:0]            len_reg;
    logic [46:0]            rem_reg;
    logic [15:0]            q_reg;
    logic [3:0]             k_reg;
    fcou_pkg::vcomp_t       res_reg [3];
    fcou_pkg::norm_stat_t   stat_reg;

    fcou_pkg::wcomp_t       cs;
    logic [29:0]            cs_abs;
    logic                   any_big;
    logic                   all_zero;
    logic [63:0]            sq_t;
    logic [63:0]            r_step;
    logic [46:0]            dsh;
    logic [15:0]            q_step;
    logic [15:0]            q_cl;

    always_comb
    begin
        case (j_reg)
            2'd0:    cs = c_reg[0];
            2'd1:    cs = c_reg[1];
            default: cs = c_reg[2];
        endcase
    end

    // magnitude fits 30 bits once prescaled
    assign cs_abs = cs[32] ? 30'(-cs) : cs[29:0];

    always_comb
    begin
        any_big = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            if ((c_reg[i] >= 33'sd1073741824) || (c_reg[i] <= -33'sd1073741824))
                any_big = 1'b1;
        end
    end

    assign all_zero = (comp_in[0] == '0) && (comp_in[1] == '0) && (comp_in[2] == '0);

    assign sq_t   = r_reg + bit_reg;
    assign r_step = (v_reg >= sq_t) ? ((r_reg >> 1) + bit_reg) : (r_reg >> 1);

    assign dsh    = 47'(len_reg) << k_reg;
    assign q_step = {q_reg[14:0], (rem_reg >= dsh)};
    assign q_cl   = (q_step > 16'd16384) ? 16'd16384 : q_step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= N_IDLE;
            j_reg     <= '0;
            acc_reg   <= '0;
            v_reg     <= '0;
            r_reg     <= '0;
            bit_reg   <= '0;
            len_reg   <= '0;
            rem_reg   <= '0;
            q_reg     <= '0;
            k_reg     <= '0;
            stat_reg  <= '0;
            for (int i = 0; i < 3; i++)
            begin
                c_reg[i]   <= '0;
                res_reg[i] <= '0;
            end
        end
        else
        begin
            stat_reg <= '0;
            unique case (state_reg)
                N_IDLE:
                begin
                    if (start)
                    begin
                        for (int i = 0; i < 3; i++)
                            c_reg[i] <= comp_in[i];
                        state_reg <= all_zero ? N_FAIL : N_SHIFT;
                    end
                end
                N_SHIFT:
                begin
                    if (any_big)
                    begin
                        for (int i = 0; i < 3; i++)
                            c_reg[i] <= c_reg[i] >>> 1;
                    end
                    else
                    begin
                        j_reg     <= '0;
                        acc_reg   <= '0;
                        state_reg <= N_SQ;
                    end
                end
                N_SQ:
                begin
                    // square one component a cycle, add the previous one
                    if (j_reg != 2'd3)
                        prod_reg <= 60'(cs_abs) * 60'(cs_abs);
                    if (j_reg != 2'd0)
                        acc_reg <= acc_reg + 62'(prod_reg);
                    if (j_reg == 2'd3)
                    begin
                        v_reg     <= 64'(acc_reg) + 64'(prod_reg);
                        r_reg     <= '0;
                        bit_reg   <= 64'd1 << 62;
                        state_reg <= N_SQRT;
                    end
                    j_reg <= j_reg + 1'b1;
                end
                N_SQRT:
                begin
                    if (v_reg >= sq_t)
                        v_reg <= v_reg - sq_t;
                    r_reg   <= r_step;
                    bit_reg <= bit_reg >> 2;
                    if (bit_reg[0])
                    begin
                        len_reg   <= r_step[30:0];
                        j_reg     <= '0;
                        state_reg <= N_DLOAD;
                    end
                end
                N_DLOAD:
                begin
                    if (len_reg == '0)
                        state_reg <= N_FAIL;
                    else
                    begin
                        rem_reg   <= 47'({cs_abs, 14'd0}) + 47'(len_reg[30:1]);
                        q_reg     <= '0;
                        k_reg     <= 4'd15;
                        state_reg <= N_DIV;
                    end
                end
                N_DIV:
                begin
                    if (rem_reg >= dsh)
                        rem_reg <= rem_reg - dsh;
                    q_reg <= q_step;
                    k_reg <= k_reg - 1'b1;
                    if (k_reg == 4'd0)
                    begin
                        res_reg[j_reg] <= cs[32] ? -q_cl : q_cl;
                        j_reg          <= j_reg + 1'b1;
                        state_reg      <= (j_reg == 2'd2) ? N_FIN : N_DLOAD;
                    end
                end
                N_FIN:
                begin
                    stat_reg.done <= 1'b1;
                    stat_reg.ok   <= 1'b1;
                    state_reg     <= N_IDLE;
                end
                N_FAIL:
                begin
                    stat_reg.done <= 1'b1;
                    stat_reg.ok   <= 1'b0;
                    state_reg     <= N_IDLE;
                end
                default:
                    state_reg <= N_IDLE;
            endcase
        end
    end

    assign res  = {res_reg[2], res_reg[1], res_reg[0]};
    assign stat = stat_reg;

endmodule

// ===== rtl/fly_camera_orientation_update.sv =====
// Fly camera orientation update: top level, request sequencer, shared multiplier, held state.
// Depends on fcou_pkg, fcou_cordic and fcou_norm.
//
//  channel   | group                     | carries
//  ----------+---------------------------+------------------------------------------
//  request   | s_tvalid/s_tready/s_tdata | direction, delta_time, offsets, constrain
//            | s_tuser                   | action
//  result    | m_tvalid/m_tready/m_tdata | position, yaw, pitch, front/right/up
//            | m_tuser                   | bad_direction
//  config    | cfg_we/cfg_addr/cfg_data  | register write, no read-back
//
// One request at a time. An invalid move or unused action goes straight to the
// result; a look or reload runs two CORDIC runs plus modulo steps, and three
// normalizations, each dominated by the 32-step square root and three 16-step
// divisions.
// The result register lets the next request in while a result waits; a
// stalled result holds the sequencer in its last state until taken.
// rst_n is asynchronous; held state returns to its start values.
module fly_camera_orientation_update #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    // request: [2:0] direction, [18:3] delta_time, [34:19] x_offset,
    // [50:35] y_offset, [51] constrain_pitch, [55:52] zero
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [55:0]   s_tdata,
    // request: [1:0] action
    input  logic [1:0]    s_tuser,
    // result: [23:0] pos_x, [47:24] pos_y, [71:48] pos_z, [91:72] out_yaw,
    // [111:92] out_pitch, [159:112] front_vector, [207:160] right_vector,
    // [255:208] up_vector
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [255:0]  m_tdata,
    // result: [0] bad_direction
    output logic [0:0]    m_tuser,
    input  logic          cfg_we,
    input  logic [2:0]    cfg_addr,
    input  logic [47:0]   cfg_data
);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MV_VEL,
        ST_MV_VLD,
        ST_MV_MUL,
        ST_MV_ADD,
        ST_LK_MX,
        ST_LK_MY,
        ST_LK_P,
        ST_LK_MOD,
        ST_TY_GO,
        ST_TY_WAIT,
        ST_TP_GO,
        ST_TP_WAIT,
        ST_F0,
        ST_F2,
        ST_F_LAST,
        ST_NGO,
        ST_N_WAIT,
        ST_CR_M,
        ST_CR_A,
        ST_OUT
    } state_t;

    // which held vector a normalization updates
    typedef enum logic [1:0] {
        TGT_FRONT,
        TGT_RIGHT,
        TGT_UP
    } tgt_t;

    // configuration
    logic [15:0]               speed_reg;
    logic [15:0]               sens_reg;
    logic [47:0]               wup_reg;
    logic signed [23:0]        start_pos_reg [3];
    logic signed [16:0]        start_yaw_reg;
    logic signed [16:0]        start_pitch_reg;

    // held camera state
    logic signed [23:0]        pos_reg [3];
    logic signed [19:0]        yaw_reg;
    logic signed [19:0]        pitch_reg;
    logic [47:0]               front_reg;
    logic [47:0]               right_reg;
    logic [47:0]               up_reg;
    logic                      bad_reg;

    // request fields
    logic [1:0]                act_reg;
    logic [2:0]                dir_reg;
    logic [15:0]               dt_reg;
    logic signed [15:0]        xo_reg;
    logic signed [15:0]        yo_reg;
    logic                      cons_reg;

    // sequencer
    state_t                    state_reg;
    tgt_t                      tgt_reg;
    logic [1:0]                j_reg;
    logic [2:0]                k_reg;
    logic                      cr_sel_reg;
    logic [31:0]               vel_reg;
    fcou_pkg::vcomp_t          sy_reg;
    fcou_pkg::vcomp_t          cy_reg;
    fcou_pkg::vcomp_t          sp_reg;
    fcou_pkg::vcomp_t          cp_reg;
    fcou_pkg::wcomp_t          ncomp_reg [3];
    logic signed [49:0]        mul_reg;

    // result register
    logic                      m_tvalid_reg;
    logic [255:0]              m_tdata_reg;
    logic [0:0]                m_tuser_reg;

    // shared multiplier
    logic signed [16:0]        mul_a;
    logic signed [32:0]        mul_b;

    logic                      s_fire;
    logic                      out_load;
    logic signed [19:0]        move_d;
    logic signed [24:0]        move_sum;
    logic signed [49:0]        look_d;
    logic signed [19:0]        look_sum;
    logic signed [19:0]        pitch_new;
    fcou_pkg::wcomp_t          mul14_val;
    logic [47:0]               move_vec;
    logic [47:0]               cr_a_vec;
    logic [47:0]               cr_b_vec;
    logic [1:0]                cr_a_idx;
    logic [1:0]                cr_b_idx;

    logic                      cor_start;
    logic signed [19:0]        cor_angle;
    logic                      cor_done;
    fcou_pkg::vcomp_t          cor_sin;
    fcou_pkg::vcomp_t          cor_cos;
    logic                      norm_start;
    logic [47:0]               norm_res;
    fcou_pkg::norm_stat_t      norm_stat;

    function automatic logic signed [23:0] sat24(input logic signed [24:0] v);
        logic signed [23:0] r;
        begin
            if (v > 25'sd8388607)
                r = 24'sh7FFFFF;
            else if (v < -25'sd8388608)
                r = 24'sh800000;
            else
                r = v[23:0];
            return r;
        end
    endfunction

    function automatic logic signed [19:0] sat20(input logic signed [41:0] v);
        logic signed [19:0] r;
        begin
            if (v > 42'sd524287)
                r = 20'sh7FFFF;
            else if (v < -42'sd524288)
                r = 20'sh80000;
            else
                r = v[19:0];
            return r;
        end
    endfunction

    // cross product term k: a[ai] * b[bi], odd terms subtract
    function automatic logic [1:0] cross_a_idx(input logic [2:0] k);
        logic [1:0] r;
        begin
            case (k)
                3'd0:    r = 2'd1;
                3'd1:    r = 2'd2;
                3'd2:    r = 2'd2;
                3'd3:    r = 2'd0;
                3'd4:    r = 2'd0;
                default: r = 2'd1;
            endcase
            return r;
        end
    endfunction

    function automatic logic [1:0] cross_b_idx(input logic [2:0] k);
        logic [1:0] r;
        begin
            case (k)
                3'd0:    r = 2'd2;
                3'd1:    r = 2'd1;
                3'd2:    r = 2'd0;
                3'd3:    r = 2'd2;
                3'd4:    r = 2'd1;
                default: r = 2'd0;
            endcase
            return r;
        end
    endfunction

    assign s_fire   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign out_load = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);

    // forward/back move along front, left/right along right
    assign move_vec = dir_reg[1] ? right_reg : front_reg;
    assign cr_a_vec = cr_sel_reg ? right_reg : front_reg;
    assign cr_b_vec = cr_sel_reg ? front_reg : wup_reg;
    assign cr_a_idx = cross_a_idx(k_reg);
    assign cr_b_idx = cross_b_idx(k_reg);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_MV_VEL:
            begin
                mul_a = 17'({1'b0, speed_reg});
                mul_b = 33'({1'b0, dt_reg});
            end
            ST_MV_MUL:
            begin
                mul_a = 17'(fcou_pkg::vec_comp(move_vec, j_reg));
                mul_b = 33'({1'b0, vel_reg});
            end
            ST_LK_MX:
            begin
                mul_a = 17'(xo_reg);
                mul_b = 33'({1'b0, sens_reg});
            end
            ST_LK_MY:
            begin
                mul_a = 17'(yo_reg);
                mul_b = 33'({1'b0, sens_reg});
            end
            ST_F0:
            begin
                mul_a = 17'(cy_reg);
                mul_b = 33'(cp_reg);
            end
            ST_F2:
            begin
                mul_a = 17'(sy_reg);
                mul_b = 33'(cp_reg);
            end
            ST_CR_M:
            begin
                mul_a = 17'(fcou_pkg::vec_comp(cr_a_vec, cr_a_idx));
                mul_b = 33'(fcou_pkg::vec_comp(cr_b_vec, cr_b_idx));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        mul_reg <= 50'(mul_a) * 50'(mul_b);
    end

    // move step: round(comp * vel / 2^30), floor after half-up bias
    always_comb
    begin
        logic signed [49:0] t;
        t        = mul_reg + 50'sd536870912;
        move_d   = t[49:30];
        if ((dir_reg == fcou_pkg::DIR_BACK) || (dir_reg == fcou_pkg::DIR_LEFT))
            move_sum = 25'(pos_reg[j_reg]) - 25'(move_d);
        else
            move_sum = 25'(pos_reg[j_reg]) + 25'(move_d);
    end

    // mouse delta: round(offset * sens / 512)
    assign look_d = (mul_reg + 50'sd256) >>> 9;

    always_comb
    begin
        look_sum  = sat20(42'(yaw_reg) + 42'(look_d));
        pitch_new = sat20(42'(pitch_reg) + 42'(look_d));
        if (cons_reg)
        begin
            if (pitch_new > 20'sd11392)
                pitch_new = 20'sd11392;
            else if (pitch_new < -20'sd11392)
                pitch_new = -20'sd11392;
        end
    end

    // Q1.14 product, half up
    assign mul14_val = 33'((mul_reg + 50'sd8192) >>> 14);

    assign cor_start  = (state_reg == ST_TY_GO) || (state_reg == ST_TP_GO);
    assign cor_angle  = (state_reg == ST_TY_GO) ? yaw_reg : pitch_reg;
    assign norm_start = (state_reg == ST_NGO);

    fcou_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cor_start),
        .angle   (cor_angle),
        .done    (cor_done),
        .sin_val (cor_sin),
        .cos_val (cor_cos)
    );

    fcou_norm u_norm (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (norm_start),
        .comp_in (ncomp_reg),
        .res     (norm_res),
        .stat    (norm_stat)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg        <= 16'd640;
            sens_reg         <= 16'd6554;
            wup_reg          <= 48'h0000_4000_0000;
            start_pos_reg[0] <= '0;
            start_pos_reg[1] <= '0;
            start_pos_reg[2] <= '0;
            start_yaw_reg    <= -17'sd11520;
            start_pitch_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                fcou_pkg::CFG_SPEED:  speed_reg        <= cfg_data[15:0];
                fcou_pkg::CFG_SENS:   sens_reg         <= cfg_data[15:0];
                fcou_pkg::CFG_WUP:    wup_reg          <= cfg_data;
                fcou_pkg::CFG_SX:     start_pos_reg[0] <= cfg_data[23:0];
                fcou_pkg::CFG_SY:     start_pos_reg[1] <= cfg_data[23:0];
                fcou_pkg::CFG_SZ:     start_pos_reg[2] <= cfg_data[23:0];
                fcou_pkg::CFG_SYAW:   start_yaw_reg    <= cfg_data[16:0];
                fcou_pkg::CFG_SPITCH: start_pitch_reg  <= cfg_data[16:0];
                default:              speed_reg        <= speed_reg;
            endcase
        end
    end

    // sequencer, held state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            tgt_reg      <= TGT_FRONT;
            j_reg        <= '0;
            k_reg        <= '0;
            cr_sel_reg   <= 1'b0;
            vel_reg      <= '0;
            sy_reg       <= '0;
            cy_reg       <= '0;
            sp_reg       <= '0;
            cp_reg       <= '0;
            pos_reg[0]   <= '0;
            pos_reg[1]   <= '0;
            pos_reg[2]   <= '0;
            yaw_reg      <= -20'sd11520;
            pitch_reg    <= '0;
            front_reg    <= 48'hC000_0000_0000;
            right_reg    <= 48'h0000_0000_4000;
            up_reg       <= 48'h0000_4000_0000;
            bad_reg      <= 1'b0;
            act_reg      <= '0;
            dir_reg      <= '0;
            dt_reg       <= '0;
            xo_reg       <= '0;
            yo_reg       <= '0;
            cons_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            m_tuser_reg  <= '0;
            for (int i = 0; i < 3; i++)
                ncomp_reg[i] <= '0;
        end
        else
        begin
            if (m_tvalid_reg && m_tready)
                m_tvalid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_fire)
                    begin
                        act_reg  <= s_tuser;
                        dir_reg  <= s_tdata[2:0];
                        dt_reg   <= s_tdata[18:3];
                        xo_reg   <= s_tdata[34:19];
                        yo_reg   <= s_tdata[50:35];
                        cons_reg <= s_tdata[51];
                        bad_reg  <= 1'b0;
                        case (s_tuser)
                            fcou_pkg::ACT_MOVE:
                            begin
                                if (s_tdata[2])
                                begin
                                    bad_reg   <= 1'b1;
                                    state_reg <= ST_OUT;
                                end
                                else
                                    state_reg <= ST_MV_VEL;
                            end
                            fcou_pkg::ACT_LOOK:
                                state_reg <= ST_LK_MX;
                            fcou_pkg::ACT_RELOAD:
                            begin
                                pos_reg[0] <= start_pos_reg[0];
                                pos_reg[1] <= start_pos_reg[1];
                                pos_reg[2] <= start_pos_reg[2];
                                yaw_reg    <= 20'(start_yaw_reg);
                                pitch_reg  <= 20'(start_pitch_reg);
                                state_reg  <= ST_TY_GO;
                            end
                            default:
                                state_reg <= ST_OUT;
                        endcase
                    end
                end
                // move: speed * dt, then each component through ST_MV_MUL and ST_MV_ADD
                ST_MV_VEL:
                    state_reg <= ST_MV_VLD;
                ST_MV_VLD:
                begin
                    vel_reg   <= mul_reg[31:0];
                    j_reg     <= '0;
                    state_reg <= ST_MV_MUL;
                end
                ST_MV_MUL:
                    state_reg <= ST_MV_ADD;
                ST_MV_ADD:
                begin
                    pos_reg[j_reg] <= sat24(move_sum);
                    j_reg          <= j_reg + 1'b1;
                    state_reg      <= (j_reg == 2'd2) ? ST_OUT : ST_MV_MUL;
                end
                // look: yaw and pitch deltas through the shared multiplier
                ST_LK_MX:
                    state_reg <= ST_LK_MY;
                ST_LK_MY:
                begin
                    yaw_reg   <= look_sum;
                    state_reg <= ST_LK_P;
                end
                ST_LK_P:
                begin
                    pitch_reg <= pitch_new;
                    state_reg <= ST_LK_MOD;
                end
                ST_LK_MOD:
                begin
                    // truncating yaw modulo of one turn
                    if (yaw_reg >= 20'sd46080)
                        yaw_reg <= yaw_reg - 20'sd46080;
                    else if (yaw_reg <= -20'sd46080)
                        yaw_reg <= yaw_reg + 20'sd46080;
                    else
                        state_reg <= ST_TY_GO;
                end
                // vector recompute
                ST_TY_GO:
                    state_reg <= ST_TY_WAIT;
                ST_TY_WAIT:
                begin
                    if (cor_done)
                    begin
                        sy_reg    <= cor_sin;
                        cy_reg    <= cor_cos;
                        state_reg <= ST_TP_GO;
                    end
                end
                ST_TP_GO:
                    state_reg <= ST_TP_WAIT;
                ST_TP_WAIT:
                begin
                    if (cor_done)
                    begin
                        sp_reg    <= cor_sin;
                        cp_reg    <= cor_cos;
                        state_reg <= ST_F0;
                    end
                end
                ST_F0:
                    state_reg <= ST_F2;
                ST_F2:
                begin
                    ncomp_reg[0] <= mul14_val;
                    state_reg    <= ST_F_LAST;
                end
                ST_F_LAST:
                begin
                    ncomp_reg[1] <= 33'(sp_reg);
                    ncomp_reg[2] <= mul14_val;
                    tgt_reg      <= TGT_FRONT;
                    state_reg    <= ST_NGO;
                end
                ST_NGO:
                    state_reg <= ST_N_WAIT;
                ST_N_WAIT:
                begin
                    if (norm_stat.done)
                    begin
                        // a zero vector keeps the held one
                        unique case (tgt_reg)
                            TGT_FRONT:
                            begin
                                if (norm_stat.ok)
                                    front_reg <= norm_res;
                                k_reg      <= '0;
                                cr_sel_reg <= 1'b0;
                                state_reg  <= ST_CR_M;
                            end
                            TGT_RIGHT:
                            begin
                                if (norm_stat.ok)
                                    right_reg <= norm_res;
                                k_reg      <= '0;
                                cr_sel_reg <= 1'b1;
                                state_reg  <= ST_CR_M;
                            end
                            default:
                            begin
                                if (norm_stat.ok)
                                    up_reg <= norm_res;
                                state_reg <= ST_OUT;
                            end
                        endcase
                    end
                end
                // cross product, six products accumulated pairwise
                ST_CR_M:
                    state_reg <= ST_CR_A;
                ST_CR_A:
                begin
                    if (k_reg[0])
                        ncomp_reg[k_reg[2:1]] <= ncomp_reg[k_reg[2:1]] - 33'(mul_reg);
                    else
                        ncomp_reg[k_reg[2:1]] <= 33'(mul_reg);
                    k_reg <= k_reg + 1'b1;
                    if (k_reg == 3'd5)
                    begin
                        tgt_reg   <= cr_sel_reg ? TGT_UP : TGT_RIGHT;
                        state_reg <= ST_NGO;
                    end
                    else
                        state_reg <= ST_CR_M;
                end
                ST_OUT:
                begin
                    if (out_load)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {up_reg, right_reg, front_reg, pitch_reg, yaw_reg,
                                         pos_reg[2], pos_reg[1], pos_reg[0]};
                        m_tuser_reg  <= bad_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef NO_ASSERTIONS
    // busy right after taking a request
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

    // only an invalid move raises the flag
    a_bad_only_move: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT) && bad_reg |-> (act_reg == fcou_pkg::ACT_MOVE))
        else $error("bad_direction on a non-move request");

    // constrained pitch stays within +-89 degrees
    a_pitch_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LK_MOD) && cons_reg |->
            (pitch_reg <= 20'sd11392) && (pitch_reg >= -20'sd11392))
        else $error("pitch clamp failed");

    // CORDIC result only arrives while waited for
    a_cordic_waited: assert property (@(posedge clk) disable iff (!rst_n)
        cor_done |-> (state_reg == ST_TY_WAIT) || (state_reg == ST_TP_WAIT))
        else $error("unexpected CORDIC result");
`endif

endmodule

// ===== test/fly_camera_orientation_update_tb.sv =====
// Self-checking testbench for fly_camera_orientation_update: directed table, then random
// requests under several config and idling phases. Depends on fcou_pkg and the block RTL.
module fly_camera_orientation_update_tb;
    import fcou_pkg::*;

    localparam int    STEPS     = 16;        // matches the block's default CORDIC_STEPS
    localparam longint CYC_LIMIT = 4000000;
    localparam int    N_PHASES  = 8;
    localparam int    PER_PHASE = 145;

    localparam longint ATAN_DEG [24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};

    typedef struct {
        logic [1:0]  action;
        logic [2:0]  dir;
        logic [15:0] dt;
        logic [15:0] xo;
        logic [15:0] yo;
        logic        cons;
    } cam_req_t;

    typedef struct {
        logic [23:0] px, py, pz;
        logic [19:0] yaw, pitch;
        logic [47:0] front, right, up;
        logic        bad;
    } cam_view_t;

    typedef struct {
        cam_req_t  rq;
        bit        typed;
        cam_view_t want;
    } dir_row_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [55:0]  s_tdata = '0;   // [2:0] dir, [18:3] dt, [34:19] x_off, [50:35] y_off, [51] cons
    logic [1:0]   s_tuser = '0;   // [1:0] action
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [255:0] m_tdata;        // px, py, pz, yaw, pitch, front, right, up from bit 0 up
    logic [0:0]   m_tuser;        // [0] bad_direction
    logic         cfg_we = 1'b0;
    logic [2:0]   cfg_addr = '0;
    logic [47:0]  cfg_data = '0;

    fly_camera_orientation_update u_top (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    // camera model state and register copies
    longint      cam_pos [3];
    longint      cam_yaw, cam_pitch;
    logic [47:0] cam_front, cam_right, cam_up;
    logic [15:0] r_speed, r_sens;
    logic [47:0] r_wup;
    logic [23:0] r_sx, r_sy, r_sz;
    logic [16:0] r_syaw, r_spitch;

    cam_view_t   view_q [$];
    int          mismatches = 0;
    int          checked = 0;
    int          sent = 0;
    longint      cycles = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          long_hold_pending = 0;

    function automatic longint clampv(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint comp_of(logic [47:0] v, int j);
        logic [15:0] c;
        c = v[16*j +: 16];
        return longint'($signed(c));
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // unit vector in Q1.14; dst is left alone for a zero vector
    function automatic void make_unit(input longint v [3], inout logic [47:0] dst);
        longint c [3];
        longint unsigned l2, len, q;
        logic [47:0] o;
        c = v;
        if (c[0] == 0 && c[1] == 0 && c[2] == 0) return;
        while ((c[0] >= 2**30 || -c[0] >= 2**30) || (c[1] >= 2**30 || -c[1] >= 2**30)
               || (c[2] >= 2**30 || -c[2] >= 2**30))
            for (int j = 0; j < 3; j++) c[j] = c[j] >>> 1;
        l2 = 0;
        for (int j = 0; j < 3; j++) l2 += c[j] * c[j];
        len = int_sqrt(l2);
        if (len == 0) return;
        for (int j = 0; j < 3; j++) begin
            q = ((c[j] < 0 ? -c[j] : c[j]) * 16384 + len / 2) / len;
            if (q > ONE14) q = ONE14;
            o[16*j +: 16] = 16'(c[j] < 0 ? -longint'(q) : longint'(q));
        end
        dst = o;
    endfunction

    function automatic void sin_cos(input longint ang, output longint s, output longint c);
        longint a, x, y, z, dx, dy;
        bit flip;
        a = ang % DEG360;
        flip = 0;
        if (a < 0) a += DEG360;
        if (a >= DEG180) a -= DEG360;
        if (a > DEG90) begin
            a -= DEG180;
            flip = 1;
        end else if (a < -DEG90) begin
            a += DEG180;
            flip = 1;
        end
        x = CORDIC_X0;
        y = 0;
        z = a * 512;
        for (int i = 0; i < STEPS && i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= ATAN_DEG[i];
            end else begin
                x += dx; y -= dy; z += ATAN_DEG[i];
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        c = clampv((x + 32768) >>> 16, -ONE14, ONE14);
        s = clampv((y + 32768) >>> 16, -ONE14, ONE14);
    endfunction

    function automatic longint q14_mul(longint a, longint b);
        return (a * b + 8192) >>> 14;
    endfunction

    function automatic void cross3(input longint a [3], input longint b [3],
                                   output longint c [3]);
        c[0] = a[1] * b[2] - a[2] * b[1];
        c[1] = a[2] * b[0] - a[0] * b[2];
        c[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    function automatic void rebuild_axes();
        longint sy, cy, sp, cp;
        longint f [3], w [3], r [3], c [3];
        sin_cos(cam_yaw, sy, cy);
        sin_cos(cam_pitch, sp, cp);
        f[0] = q14_mul(cy, cp);
        f[1] = sp;
        f[2] = q14_mul(sy, cp);
        make_unit(f, cam_front);
        for (int j = 0; j < 3; j++) begin
            f[j] = comp_of(cam_front, j);
            w[j] = comp_of(r_wup, j);
        end
        cross3(f, w, c);
        make_unit(c, cam_right);
        for (int j = 0; j < 3; j++) r[j] = comp_of(cam_right, j);
        cross3(r, f, c);
        make_unit(c, cam_up);
    endfunction

    function automatic void camera_reset();
        r_speed = 16'd640;
        r_sens = 16'd6554;
        r_wup = 48'h0000_4000_0000;
        r_sx = '0; r_sy = '0; r_sz = '0;
        r_syaw = 17'(-DEG90);
        r_spitch = '0;
        cam_pos = '{0, 0, 0};
        cam_yaw = -DEG90;
        cam_pitch = 0;
        cam_front = 48'hC000_0000_0000;
        cam_right = 48'h0000_0000_4000;
        cam_up = 48'h0000_4000_0000;
    endfunction

    // advance the camera by one request and return the view it reports
    function automatic cam_view_t camera_step(cam_req_t r);
        cam_view_t v;
        longint vel, d, dyaw, dpit;
        logic [47:0] axis;
        v.bad = 1'b0;
        if (r.action == ACT_MOVE) begin
            if (r.dir > DIR_RIGHT)
                v.bad = 1'b1;
            else begin
                vel = longint'(r_speed) * longint'(r.dt);
                axis = (r.dir == DIR_FWD || r.dir == DIR_BACK) ? cam_front : cam_right;
                for (int j = 0; j < 3; j++) begin
                    d = (comp_of(axis, j) * vel + (64'sd1 <<< 29)) >>> 30;
                    if (r.dir == DIR_BACK || r.dir == DIR_LEFT) d = -d;
                    cam_pos[j] = clampv(cam_pos[j] + d, -(2**23), 2**23 - 1);
                end
            end
        end else if (r.action == ACT_LOOK) begin
            dyaw = (longint'($signed(r.xo)) * longint'(r_sens) + 256) >>> 9;
            dpit = (longint'($signed(r.yo)) * longint'(r_sens) + 256) >>> 9;
            cam_yaw = clampv(cam_yaw + dyaw, -(2**19), 2**19 - 1);
            cam_pitch = clampv(cam_pitch + dpit, -(2**19), 2**19 - 1);
            if (r.cons) cam_pitch = clampv(cam_pitch, -DEG89, DEG89);
            cam_yaw = cam_yaw % DEG360;
            rebuild_axes();
        end else if (r.action == ACT_RELOAD) begin
            cam_pos[0] = longint'($signed(r_sx));
            cam_pos[1] = longint'($signed(r_sy));
            cam_pos[2] = longint'($signed(r_sz));
            cam_yaw = longint'($signed(r_syaw));
            cam_pitch = longint'($signed(r_spitch));
            rebuild_axes();
        end
        // unused action code: state shown as is
        v.px = 24'(cam_pos[0]);
        v.py = 24'(cam_pos[1]);
        v.pz = 24'(cam_pos[2]);
        v.yaw = 20'(cam_yaw);
        v.pitch = 20'(cam_pitch);
        v.front = cam_front;
        v.right = cam_right;
        v.up = cam_up;
        return v;
    endfunction

    function automatic cam_req_t mk_req(logic [1:0] a, logic [2:0] d, logic [15:0] dt,
                                        logic [15:0] xo, logic [15:0] yo, logic c);
        cam_req_t r;
        r.action = a; r.dir = d; r.dt = dt; r.xo = xo; r.yo = yo; r.cons = c;
        return r;
    endfunction

    function automatic cam_req_t rand_req();
        cam_req_t r;
        int k;
        k = $urandom_range(99);
        r.action = k < 45 ? ACT_MOVE : (k < 85 ? ACT_LOOK : (k < 96 ? ACT_RELOAD : 2'd3));
        r.dir = $urandom_range(99) < 85 ? 3'($urandom_range(3)) : 3'($urandom_range(7, 4));
        r.dt = 16'($urandom);
        if ($urandom_range(1)) begin
            r.xo = 16'($urandom);
            r.yo = 16'($urandom);
        end else begin
            // small mouse steps keep the angles in range for a while
            r.xo = 16'($urandom_range(400) - 200);
            r.yo = 16'($urandom_range(400) - 200);
        end
        r.cons = $urandom_range(1);
        return r;
    endfunction

    task automatic flag_field(string name, logic [63:0] want, logic [63:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("result %0d: %s expected %h, got %h", checked, name, want, got);
    endtask

    // send one request; the expected view is queued at acceptance
    task automatic send_request(cam_req_t r, bit typed, cam_view_t want);
        cam_view_t v;
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(8, 1)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {4'b0, r.cons, r.yo, r.xo, r.dt, r.dir};
        s_tuser <= r.action;
        do @(posedge clk); while (!s_tready);
        v = camera_step(r);
        view_q.push_back(typed ? want : v);
        sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        wait (view_q.size() == 0);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [47:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        case (idx)
            CFG_SPEED:  r_speed = val[15:0];
            CFG_SENS:   r_sens = val[15:0];
            CFG_WUP:    r_wup = val;
            CFG_SX:     r_sx = val[23:0];
            CFG_SY:     r_sy = val[23:0];
            CFG_SZ:     r_sz = val[23:0];
            CFG_SYAW:   r_syaw = val[16:0];
            default:    r_spitch = val[16:0];
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [16:0] rand_angle();
        return 17'(int'($urandom_range(92160)) - DEG360);
    endfunction

    task automatic config_for_phase(int p);
        case (p)
            1: begin
                write_reg(CFG_SPEED, 48'hFFFF);
                write_reg(CFG_SENS, 48'hFFFF);
                write_reg(CFG_SX, 48'h7F_FFFF);
                write_reg(CFG_SY, 48'h80_0000);
                write_reg(CFG_SZ, 48'h7F_FFFF);
                write_reg(CFG_SYAW, 48'(17'(DEG360)));
                write_reg(CFG_SPITCH, 48'(17'(DEG360)));
            end
            2: begin
                // zero world up: right must hold its value, up is rebuilt from the held right
                write_reg(CFG_SPEED, 48'h0);
                write_reg(CFG_SENS, 48'h0);
                write_reg(CFG_WUP, 48'h0);
                write_reg(CFG_SX, 48'h80_0000);
                write_reg(CFG_SY, 48'h7F_FFFF);
                write_reg(CFG_SZ, 48'h80_0000);
                write_reg(CFG_SYAW, 48'(17'(-DEG360)));
                write_reg(CFG_SPITCH, 48'(17'(-DEG360)));
            end
            3: begin
                // looking straight up: front parallel to world up
                write_reg(CFG_SPEED, 48'd640);
                write_reg(CFG_SENS, 48'd6554);
                write_reg(CFG_WUP, 48'h0000_4000_0000);
                write_reg(CFG_SYAW, 48'h0);
                write_reg(CFG_SPITCH, 48'(17'(DEG90)));
            end
            default: begin
                write_reg(CFG_SPEED, 48'($urandom));
                write_reg(CFG_SENS, 48'($urandom_range(20000)));
                write_reg(CFG_WUP, $urandom_range(1) ? {16'($urandom), 32'($urandom)}
                                                     : 48'(16'h4000) << (16 * $urandom_range(2)));
                write_reg(CFG_SX, 48'($urandom));
                write_reg(CFG_SY, 48'($urandom));
                write_reg(CFG_SZ, 48'($urandom));
                write_reg(CFG_SYAW, 48'(rand_angle()));
                write_reg(CFG_SPITCH, 48'(rand_angle()));
            end
        endcase
    endtask

    // result checker
    always @(posedge clk) begin
        cam_view_t w;
        if (rst_n && m_tvalid && m_tready) begin
            if (view_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("result with nothing pending");
            end else begin
                w = view_q.pop_front();
                if (m_tdata[23:0] !== w.px)      flag_field("pos_x", w.px, m_tdata[23:0]);
                if (m_tdata[47:24] !== w.py)     flag_field("pos_y", w.py, m_tdata[47:24]);
                if (m_tdata[71:48] !== w.pz)     flag_field("pos_z", w.pz, m_tdata[71:48]);
                if (m_tdata[91:72] !== w.yaw)    flag_field("yaw", w.yaw, m_tdata[91:72]);
                if (m_tdata[111:92] !== w.pitch) flag_field("pitch", w.pitch, m_tdata[111:92]);
                if (m_tdata[159:112] !== w.front)
                    flag_field("front", w.front, m_tdata[159:112]);
                if (m_tdata[207:160] !== w.right)
                    flag_field("right", w.right, m_tdata[207:160]);
                if (m_tdata[255:208] !== w.up)   flag_field("up", w.up, m_tdata[255:208]);
                if (m_tuser[0] !== w.bad)        flag_field("bad_direction", w.bad, m_tuser[0]);
            end
            checked++;
        end
    end

    // receiver: random stalls, plus one long hold-off counted here
    initial begin
        forever begin
            @(negedge clk);
            if (long_hold_pending) begin
                long_hold_pending = 0;
                m_tready <= 1'b0;
                repeat (3000) @(negedge clk);
            end
            m_tready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYC_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        dir_row_t  rows [$];
        cam_view_t home, none;
        cam_req_t  rq;

        camera_reset();
        home.px = '0; home.py = '0; home.pz = '0;
        home.yaw = 20'hFD300;                  // -90 degrees
        home.pitch = '0;
        home.front = 48'hC000_0000_0000;       // (0, 0, -1)
        home.right = 48'h0000_0000_4000;       // (1, 0, 0)
        home.up = 48'h0000_4000_0000;          // (0, 1, 0)
        home.bad = 1'b0;
        none = home;

        // directed table; typed rows expect the reset view, the second one with bad set
        rows.push_back('{mk_req(2'd3, 3'd0, 16'h0, 16'h0, 16'h0, 1'b0), 1'b1, home});
        home.bad = 1'b1;
        rows.push_back('{mk_req(ACT_MOVE, 3'd5, 16'hFFFF, 16'h0, 16'h0, 1'b0), 1'b1, home});
        rows.push_back('{mk_req(ACT_MOVE, DIR_FWD, 16'hFFFF, 16'h0, 16'h0, 1'b0), 1'b0, none});
        rows.push_back('{mk_req(ACT_MOVE, DIR_BACK, 16'h8000, 16'h0, 16'h0, 1'b1), 1'b0, none});
        rows.push_back('{mk_req(ACT_MOVE, DIR_LEFT, 16'h0001, 16'hFFFF, 16'hFFFF, 1'b0), 1'b0, none});
        rows.push_back('{mk_req(ACT_MOVE, DIR_RIGHT, 16'hFFFF, 16'h0, 16'h0, 1'b0), 1'b0, none});
        rows.push_back('{mk_req(ACT_MOVE, DIR_FWD, 16'h0, 16'h0, 16'h0, 1'b0), 1'b0, none});
        rows.push_back('{mk_req(ACT_MOVE, 3'd4, 16'h1234, 16'h0, 16'h0, 1'b0), 1'b0, none});
        rows.push_back('{mk_req(ACT_MOVE, 3'd7, 16'hFFFF, 16'h0, 16'h0, 1'b1), 1'b0, none});
        rows.push_back('{mk_req(ACT_LOOK, 3'd0, 16'h0, 16'h0, 16'h0, 1'b0), 1'b0, none});
        rows.push_back('{mk_req(ACT_LOOK, 3'd0, 16'h0, 16'h7FFF, 16'h7FFF, 1'b1), 1'b0, none});
        rows.push_back('{mk_req(ACT_LOOK, 3'd0, 16'h0, 16'h8000, 16'h8000, 1'b1), 1'b0, none});
        rows.push_back('{mk_req(ACT_LOOK, 3'd0, 16'h0, 16'h7FFF, 16'h7FFF, 1'b0), 1'b0, none});
        rows.push_back('{mk_req(ACT_LOOK, 3'd0, 16'h0, 16'h7FFF, 16'h7FFF, 1'b0), 1'b0, none});
        rows.push_back('{mk_req(ACT_LOOK, 3'd0, 16'h0, 16'h8000, 16'h8000, 1'b0), 1'b0, none});
        rows.push_back('{mk_req(ACT_MOVE, DIR_LEFT, 16'hFFFF, 16'h0, 16'h0, 1'b0), 1'b0, none});
        rows.push_back('{mk_req(ACT_RELOAD, 3'd0, 16'h0, 16'h0, 16'h0, 1'b0), 1'b0, none});
        // pitch to +90 unclamped: front along world up, cross product vanishes
        rows.push_back('{mk_req(ACT_LOOK, 3'd0, 16'h0, 16'h0, 16'd900, 1'b0), 1'b0, none});
        rows.push_back('{mk_req(ACT_LOOK, 3'd0, 16'h0, 16'h0, 16'hFFFF, 1'b1), 1'b0, none});
        rows.push_back('{mk_req(ACT_MOVE, DIR_RIGHT, 16'h4000, 16'h0, 16'h0, 1'b0), 1'b0, none});
        rows.push_back('{mk_req(2'd3, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1), 1'b0, none});

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        recv_stall_pct = 30;
        foreach (rows[i]) send_request(rows[i].rq, rows[i].typed, rows[i].want);
        drain();

        for (int p = 0; p < N_PHASES; p++) begin
            if (p > 0) config_for_phase(p);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
                default: begin send_idle_pct = 30; recv_stall_pct = 30; end
            endcase
            // reload first so each phase starts from its start registers
            send_request(mk_req(ACT_RELOAD, 3'd0, 16'h0, 16'h0, 16'h0, 1'b0), 1'b0, none);
            if (p == 1) long_hold_pending = 1;
            for (int i = 0; i < PER_PHASE; i++) begin
                if ($urandom_range(199) == 0) drain();
                rq = rand_req();
                send_request(rq, 1'b0, none);
            end
            drain();
        end

        $display("%0d requests over %0d config phases, %0d results checked", sent,
                 N_PHASES + 1, checked);
        if (mismatches == 0 && view_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== fly_camera_orientation_update.f =====
rtl/fcou_pkg.sv
rtl/fcou_cordic.sv
rtl/fcou_norm.sv
rtl/fly_camera_orientation_update.sv
test/fly_camera_orientation_update_tb.sv
